[src/bts_pkg.sv]
// Shared types and constants for the blob target selector.
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_DBAND = 2'd2;

	// Selection strategies
	localparam logic [1:0] MODE_AREA    = 2'd0;
	localparam logic [1:0] MODE_CENTRE  = 2'd1;
	localparam logic [1:0] MODE_LEFT    = 2'd2;
	localparam logic [1:0] MODE_LOWEST  = 2'd3;

	// Verdict codes
	localparam logic [1:0] VERDICT_NONE    = 2'd0;
	localparam logic [1:0] VERDICT_FORWARD = 2'd1;
	localparam logic [1:0] VERDICT_RIGHT   = 2'd2;
	localparam logic [1:0] VERDICT_LEFT    = 2'd3;

	// Reset values of the configuration registers
	localparam logic [11:0] WIDTH_RESET = 12'd640;
	localparam logic [14:0] DBAND_RESET = 15'd1280;

	// Saturation limits
	localparam logic [27:0] BEARING_MAX = 28'd23040;
	localparam logic [27:0] Q15_POS_MAX = 28'd32767;
	localparam logic [27:0] Q15_NEG_MAX = 28'd32768;

	// Bearing scale: 90 degrees in Q8.8 over half a frame of 1/16 pixels
	localparam logic [11:0] BEARING_SCALE = 12'd2880;

	// Dividend width of the bit-serial divider
	localparam int DIV_BITS = 28;

	// Frame summary passed from front to back
	typedef struct packed {
		logic [7:0]  count;
		logic        have_best;
		logic [7:0]  index;
		logic [2:0]  colour;
		logic [15:0] best_x;
	} bts_rec_t;

	// Result item
	typedef struct packed {
		logic [7:0]  object_count;
		logic [7:0]  target_index;
		logic [2:0]  target_colour;
		logic [15:0] bearing;
		logic [15:0] offset_norm;
		logic [6:0]  turn_degrees;
		logic [1:0]  verdict;
	} bts_res_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SETUP,
		BK_DIV,
		BK_FIN
	} bts_bk_state_t;

endpackage
`default_nettype wire

[src/blob_target_selector_bearing_top.sv]
// Top level of the blob target selector: config registers, front, queue, back.
`timescale 1ns / 1ps
`default_nettype none
// Blobs are taken one per cycle while full is low; the front keeps the running count and best blob and, at
// the item that ends a frame, files a summary into a two-entry queue. The back turns each
// summary into a result in these steps: dequeue, setup with the two multiplies, a bit-serial
// divider over the 28-bit dividend producing bearing and offset together, and finish.
// full rises only while two frame summaries wait, so input stalls when frames end faster than
// the back turns summaries into results or when results are not taken. Configuration takes effect
// for the next blob; change it only while no frame summary or result is pending.
module blob_target_selector_bearing_top import bts_pkg::*; #(
	parameter int COUNT_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [14:0] cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] center_x,
	input  wire logic [15:0] center_y,
	input  wire logic [24:0] blob_area,
	input  wire logic [2:0]  colour_id,
	input  wire logic        no_object,
	input  wire logic        frame_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       object_count,
	output logic [7:0]       target_index,
	output logic [2:0]       target_colour,
	output logic signed [15:0] bearing,
	output logic signed [15:0] offset_norm,
	output logic [6:0]       turn_degrees,
	output logic [1:0]       verdict
);

	logic [1:0]  mode_q;
	logic [11:0] width_q;
	logic [14:0] dband_q;
	logic [11:0] width_eff;
	logic        in_acc;
	logic        rec_push, q_pop, q_empty, res_valid;
	bts_rec_t    wr_rec, rd_rec;
	bts_res_t    res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_AREA;
			width_q <= WIDTH_RESET;
			dband_q <= DBAND_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MODE:  mode_q  <= cfg_wdata[1:0];
				REG_WIDTH: width_q <= cfg_wdata[11:0];
				REG_DBAND: dband_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Zero width counts as one pixel
	assign width_eff = (width_q == '0) ? 12'd1 : width_q;
	assign in_acc    = push && !full;

	bts_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.center_x (center_x),
		.center_y (center_y),
		.blob_area(blob_area),
		.colour_id(colour_id),
		.no_object(no_object),
		.frame_end(frame_end),
		.mode     (mode_q),
		.centre   ({width_eff, 3'b000}),
		.rec_push (rec_push),
		.rec      (wr_rec)
	);

	bts_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wr_rec(wr_rec),
		.pop   (q_pop),
		.rd_rec(rd_rec),
		.full  (full),
		.empty (q_empty)
	);

	bts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.width    (width_eff),
		.dead_band(dband_q),
		.q_empty  (q_empty),
		.q_rec    (rd_rec),
		.q_pop    (q_pop),
		.res_pop  (pop && res_valid),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result ports
	assign empty         = !res_valid;
	assign object_count  = res.object_count;
	assign target_index  = res.target_index;
	assign target_colour = res.target_colour;
	assign bearing       = res.bearing;
	assign offset_norm   = res.offset_norm;
	assign turn_degrees  = res.turn_degrees;
	assign verdict       = res.verdict;

endmodule
`default_nettype wire

[src/bts_front.sv]
// Front end: per-blob count and best-target tracking, one summary per frame.
`timescale 1ns / 1ps
`default_nettype none
module bts_front import bts_pkg::*; #(
	parameter int COUNT_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_acc,
	input  wire logic [15:0] center_x,
	input  wire logic [15:0] center_y,
	input  wire logic [24:0] blob_area,
	input  wire logic [2:0]  colour_id,
	input  wire logic        no_object,
	input  wire logic        frame_end,
	input  wire logic [1:0]  mode,
	input  wire logic [14:0] centre,
	output logic             rec_push,
	output bts_rec_t         rec
);

	localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [24:0]           key_q, key_d, key_new;
	logic [15:0]           bx_q, bx_d;
	logic [COUNT_BITS-1:0] bidx_q, bidx_d;
	logic [2:0]            bcol_q, bcol_d;
	logic                  have_q, have_d;
	logic                  take;
	logic [15:0]           cdist;
	logic [CW-1:0]         cnt_w, idx_w;

	// Key of the incoming blob and whether it beats the best so far
	always_comb begin
		cdist = (center_x >= {1'b0, centre}) ? center_x - {1'b0, centre}
			: {1'b0, centre} - center_x;
		case (mode)
			MODE_AREA: begin
				key_new = blob_area;
				take    = key_new > key_q;
			end
			MODE_CENTRE: begin
				key_new = {9'd0, cdist};
				take    = key_new < key_q;
			end
			MODE_LEFT: begin
				key_new = {9'd0, center_x};
				take    = key_new < key_q;
			end
			default: begin
				key_new = {9'd0, center_y};
				take    = key_new > key_q;
			end
		endcase
	end

	// Running state after this item
	always_comb begin
		cnt_d  = cnt_q;
		key_d  = key_q;
		bx_d   = bx_q;
		bidx_d = bidx_q;
		bcol_d = bcol_q;
		have_d = have_q;
		if (!no_object) begin
			if (!have_q || take) begin
				have_d = 1'b1;
				key_d  = key_new;
				bx_d   = center_x;
				bidx_d = cnt_q;
				bcol_d = colour_id;
			end
			if (cnt_q != CNT_MAX) begin
				cnt_d = cnt_q + 1'b1;
			end
		end
	end

	// Frame summary, fields masked to 8 bits
	always_comb begin
		cnt_w         = CW'(cnt_d);
		idx_w         = CW'(bidx_d);
		rec_push      = in_acc && frame_end;
		rec.count     = cnt_w[7:0];
		rec.have_best = have_d;
		rec.index     = idx_w[7:0];
		rec.colour    = bcol_d;
		rec.best_x    = bx_d;
	end

	// Tracking registers, cleared at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			key_q  <= '0;
			bx_q   <= '0;
			bidx_q <= '0;
			bcol_q <= '0;
			have_q <= 1'b0;
		end else if (in_acc) begin
			if (frame_end) begin
				cnt_q  <= '0;
				key_q  <= '0;
				bx_q   <= '0;
				bidx_q <= '0;
				bcol_q <= '0;
				have_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_d;
				key_q  <= key_d;
				bx_q   <= bx_d;
				bidx_q <= bidx_d;
				bcol_q <= bcol_d;
				have_q <= have_d;
			end
		end
	end

endmodule
`default_nettype wire

[src/bts_fifo.sv]
// Two-entry queue of frame summaries between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bts_fifo import bts_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire bts_rec_t wr_rec,
	input  wire logic     pop,
	output bts_rec_t      rd_rec,
	output logic          full,
	output logic          empty
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	bts_rec_t         mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      fill_q;

	assign full   = (fill_q == (PW+1)'(DEPTH));
	assign empty  = (fill_q == '0);
	assign rd_rec = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[src/bts_back.sv]
// Back end: bearing and offset by bit-serial division, verdict, result register.
`timescale 1ns / 1ps
`default_nettype none
module bts_back import bts_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [11:0] width,
	input  wire logic [14:0] dead_band,
	input  wire logic        q_empty,
	input  wire bts_rec_t    q_rec,
	output logic             q_pop,
	input  wire logic        res_pop,
	output logic             res_valid,
	output bts_res_t         res
);

	localparam int DCW = $clog2(DIV_BITS);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_BITS - 1);

	bts_bk_state_t          state_q, state_d;
	bts_rec_t               rec_q;
	logic                   neg_q, fwd_q;
	logic [DIV_BITS-1:0]    bnum_q, onum_q, bquo_q, oquo_q;
	logic [12:0]            brem_q, orem_q;
	logic [DCW-1:0]         dcnt_q;
	logic                   valid_q;
	bts_res_t               res_q, res_new;

	logic [14:0]            centre;
	logic                   neg;
	logic [15:0]            dmag;
	logic [27:0]            bprod;
	logic [26:0]            dprod;
	logic [12:0]            bshift, oshift;
	logic                   bge, oge;
	logic [27:0]            bsat, omag;
	logic                   load_res;

	assign res_valid = valid_q;
	assign res       = res_q;

	// Offset magnitude and products from the dequeued summary
	always_comb begin
		centre = {width, 3'b000};
		neg    = rec_q.best_x < {1'b0, centre};
		dmag   = neg ? {1'b0, centre} - rec_q.best_x : rec_q.best_x - {1'b0, centre};
		bprod  = 28'(dmag) * 28'(BEARING_SCALE);
		dprod  = 27'(dead_band) * 27'(width);
	end

	// One restoring divide step on both quotients
	always_comb begin
		bshift = {brem_q[11:0], bnum_q[DIV_BITS-1]};
		oshift = {orem_q[11:0], onum_q[DIV_BITS-1]};
		bge    = bshift >= {1'b0, width};
		oge    = oshift >= {1'b0, width};
	end

	// Saturation and result assembly
	always_comb begin
		bsat = (bquo_q > BEARING_MAX) ? BEARING_MAX : bquo_q;
		if (neg_q) begin
			omag = (oquo_q > Q15_NEG_MAX) ? Q15_NEG_MAX : oquo_q;
		end else begin
			omag = (oquo_q > Q15_POS_MAX) ? Q15_POS_MAX : oquo_q;
		end
		res_new.object_count = rec_q.count;
		if (rec_q.have_best) begin
			res_new.target_index  = rec_q.index;
			res_new.target_colour = rec_q.colour;
			res_new.bearing       = neg_q ? 16'(-bsat[15:0]) : bsat[15:0];
			res_new.offset_norm   = neg_q ? 16'(-omag[15:0]) : omag[15:0];
			res_new.turn_degrees  = bsat[14:8];
			if (fwd_q) begin
				res_new.verdict = VERDICT_FORWARD;
			end else if (neg_q) begin
				res_new.verdict = VERDICT_LEFT;
			end else begin
				res_new.verdict = VERDICT_RIGHT;
			end
		end else begin
			res_new.target_index  = '0;
			res_new.target_colour = '0;
			res_new.bearing       = '0;
			res_new.offset_norm   = '0;
			res_new.turn_degrees  = '0;
			res_new.verdict       = VERDICT_NONE;
		end
	end

	// Sequencer next state
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_res = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_SETUP;
				end
			end
			BK_SETUP: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (dcnt_q == DIV_LAST) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (!valid_q || res_pop) begin
					load_res = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				valid_q <= 1'b1;
			end else if (res_pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_rec;
		end
		if (state_q == BK_SETUP) begin
			neg_q  <= neg;
			fwd_q  <= {1'b0, dprod} >= bprod;
			bnum_q <= bprod;
			onum_q <= {dmag, 12'd0};
			brem_q <= '0;
			orem_q <= '0;
			bquo_q <= '0;
			oquo_q <= '0;
			dcnt_q <= '0;
		end
		if (state_q == BK_DIV) begin
			bnum_q <= {bnum_q[DIV_BITS-2:0], 1'b0};
			onum_q <= {onum_q[DIV_BITS-2:0], 1'b0};
			brem_q <= bge ? bshift - {1'b0, width} : bshift;
			orem_q <= oge ? oshift - {1'b0, width} : oshift;
			bquo_q <= {bquo_q[DIV_BITS-2:0], bge};
			oquo_q <= {oquo_q[DIV_BITS-2:0], oge};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (load_res) begin
			res_q <= res_new;
		end
	end

endmodule
`default_nettype wire

[src/bts_checker.sv]
// Port-level checks on the result side of the blob target selector, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module bts_checker import bts_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [7:0]  object_count,
	input  wire logic [15:0] bearing,
	input  wire logic [15:0] offset_norm,
	input  wire logic [6:0]  turn_degrees,
	input  wire logic [1:0]  verdict
);

	// A waiting result holds until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(verdict) && $stable(bearing)
			&& $stable(offset_norm)))
		else $error("result changed before transfer");

	// An empty frame has no target and no angle
	a_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && object_count == 8'd0) |-> (verdict == VERDICT_NONE
			&& bearing == 16'd0 && offset_norm == 16'd0 && turn_degrees == 7'd0))
		else $error("empty frame reported a target");

	// A right turn never carries a negative angle
	a_right_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && verdict == VERDICT_RIGHT) |-> (!bearing[15] && !offset_norm[15]))
		else $error("right verdict with negative bearing");

	// Turn stays within a quarter turn
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (turn_degrees <= 7'd90))
		else $error("turn beyond 90 degrees");

endmodule

bind blob_target_selector_bearing_top bts_checker u_bts_checker (.*);
`default_nettype wire
